FILE: rtl/gbcd_pkg.sv
// ----------------------------------------------------------------------------
// gbcd_pkg
// Shared types, codes and helpers of the greedy bounded change dispenser.
// ----------------------------------------------------------------------------
package gbcd_pkg;

  localparam int unsigned VAL_W       = 16;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned AMT_W       = 24;
  localparam int unsigned IDX_W       = 6;   // load index, covers up to 64 entries
  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_DISPENSE = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LINE       = 3'd0,
    ST_IMPOSSIBLE = 3'd1,
    ST_NOTHING    = 3'd2,
    ST_LOADED     = 3'd3,
    ST_REJECTED   = 3'd4,
    ST_CLEARED    = 3'd5
  } status_t;

  // One denomination as it travels along the cell chain
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] take;
  } gbcd_item_t;

  // Per-cycle command to every cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic rotate;
    logic largest_first;
  } gbcd_ctrl_t;

  // True when a must be visited before b; equal values keep load order
  function automatic logic goes_before(gbcd_item_t a, gbcd_item_t b, logic largest_first);
    logic better;
    better = largest_first ? (a.value > b.value) : (a.value < b.value);
    return better || ((a.value == b.value) && (a.idx < b.idx));
  endfunction

endpackage

FILE: rtl/gbcd_cell.sv
// ----------------------------------------------------------------------------
// gbcd_cell
// One slot of the sorting chain: keeps the better of its entry and the beat
// from the left and passes the other right; in rotate mode takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module gbcd_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  gbcd_pkg::gbcd_ctrl_t   ctrl,
  input  gbcd_pkg::gbcd_item_t   left_in,
  input  gbcd_pkg::gbcd_item_t   right_in,
  output gbcd_pkg::gbcd_item_t   held,
  output gbcd_pkg::gbcd_item_t   pass
);

  // held entry and outgoing beat
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else if (ctrl.clear) begin
      held.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (!left_in.valid) begin
        pass.valid <= 1'b0;
      end else if (!held.valid) begin
        held       <= left_in;
        pass.valid <= 1'b0;
      end else if (gbcd_pkg::goes_before(left_in, held, ctrl.largest_first)) begin
        held <= left_in;
        pass <= held;
      end else begin
        pass <= left_in;
      end
    end else if (ctrl.rotate) begin
      held       <= right_in;
      pass.valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/gbcd_div.sv
// ----------------------------------------------------------------------------
// gbcd_div
// Restoring divider, one quotient bit per cycle: amount by denomination.
// ----------------------------------------------------------------------------
module gbcd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gbcd_pkg::AMT_W-1:0]  dividend,
  input  logic [gbcd_pkg::VAL_W-1:0]  divisor,
  output logic                        done,
  output logic [gbcd_pkg::AMT_W-1:0]  quotient
);

  localparam int unsigned STEP_W = $clog2(gbcd_pkg::AMT_W);

  logic                        busy;
  logic [STEP_W-1:0]           step;
  logic [gbcd_pkg::VAL_W:0]    rmd;
  logic [gbcd_pkg::VAL_W-1:0]  dvs;
  logic [gbcd_pkg::VAL_W:0]    trial;
  logic                        fits;

  // shift in next dividend bit and try a subtract
  always_comb begin
    trial = {rmd[gbcd_pkg::VAL_W-1:0], quotient[gbcd_pkg::AMT_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        quotient <= dividend;
        rmd      <= '0;
        dvs      <= divisor;
      end else if (busy) begin
        rmd      <= fits ? (trial - {1'b0, dvs}) : trial;
        quotient <= {quotient[gbcd_pkg::AMT_W-2:0], fits};
        step     <= step + STEP_W'(1);
        if (step == STEP_W'(gbcd_pkg::AMT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/greedy_bounded_change_dispenser.sv
// ----------------------------------------------------------------------------
// greedy_bounded_change_dispenser
// Load, clear and greedy dispense over a table of bounded denominations.
// ----------------------------------------------------------------------------
// Load and clear: the result is registered on the next edge.
// Dispense: the table is first fed through the D-cell chain, which sorts it,
// then D walk steps, each a skip or, while the amount is unmet, a divide,
// multiply and subtract; one check state; D emit steps, held by output stalls.
// One item in flight at a time: the input stalls while the block is busy.
// Synchronous reset empties the table, sets largest_first to 1, drops output.
// ----------------------------------------------------------------------------
module greedy_bounded_change_dispenser #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [gbcd_pkg::VAL_W-1:0]  denom_value,
  input  logic [gbcd_pkg::CNT_W-1:0]  denom_count,
  input  logic [gbcd_pkg::AMT_W-1:0]  amount,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status,
  output logic [gbcd_pkg::VAL_W-1:0]  out_value,
  output logic [gbcd_pkg::CNT_W-1:0]  out_count,
  output logic                        last
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FW = $clog2(2 * TABLE_DEPTH + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_FEED, S_WALK, S_DIV, S_MUL, S_SUB, S_CHECK, S_EMIT
  } state_t;

  state_t                           state;
  logic                             largest_first;
  logic [UW-1:0]                    used;
  logic [FW-1:0]                    feed_cnt;
  logic [UW-1:0]                    step;
  logic [UW-1:0]                    lines;
  logic [UW-1:0]                    emitted;
  logic [gbcd_pkg::AMT_W-1:0]       rem;
  logic [gbcd_pkg::CNT_W-1:0]       take;
  logic [gbcd_pkg::VAL_W+gbcd_pkg::CNT_W-1:0] prod;

  // table memory and its registered read port
  logic [gbcd_pkg::VAL_W-1:0]       tbl_value [TABLE_DEPTH];
  logic [gbcd_pkg::CNT_W-1:0]       tbl_count [TABLE_DEPTH];
  logic                             rd_valid;
  logic [gbcd_pkg::VAL_W-1:0]       rd_value;
  logic [gbcd_pkg::CNT_W-1:0]       rd_count;
  logic [gbcd_pkg::IDX_W-1:0]       rd_idx;

  // chain
  gbcd_pkg::gbcd_ctrl_t             ctrl;
  gbcd_pkg::gbcd_item_t             feed_item;
  gbcd_pkg::gbcd_item_t             wrap_item;
  gbcd_pkg::gbcd_item_t             held [TABLE_DEPTH];
  gbcd_pkg::gbcd_item_t             pass [TABLE_DEPTH];

  // divider
  logic                             div_start;
  logic                             div_done;
  logic [gbcd_pkg::AMT_W-1:0]       div_q;

  logic                             in_acc;
  logic                             out_free;
  logic                             load_ok;
  logic                             head_live;
  logic                             is_line;
  logic                             step_end;
  logic                             fail;
  logic [gbcd_pkg::CNT_W-1:0]       take_next;

  // handshake and decode
  always_comb begin
    out_free  = !out_valid || !out_stall;
    in_stall  = (state != S_IDLE) || !out_free;
    in_acc    = in_valid && !in_stall;
    load_ok   = (denom_value != '0) && (used != UW'(TABLE_DEPTH));
    head_live = held[0].valid && (rem != '0);
    is_line   = held[0].valid && (held[0].take != '0);
    step_end  = (step == UW'(TABLE_DEPTH - 1));
    fail      = (rem != '0) || (32'(lines) > gbcd_pkg::MAX_RESULTS);
    take_next = (div_q < {{(gbcd_pkg::AMT_W - gbcd_pkg::CNT_W){1'b0}}, held[0].count})
                ? div_q[gbcd_pkg::CNT_W-1:0] : held[0].count;
    div_start = (state == S_WALK) && head_live;
  end

  // chain control and the beats entering both ends
  always_comb begin
    ctrl.clear         = in_acc && (command == gbcd_pkg::CMD_DISPENSE);
    ctrl.insert        = (state == S_FEED);
    ctrl.rotate        = ((state == S_WALK) && !head_live) || (state == S_SUB) ||
                         ((state == S_EMIT) && (!is_line || out_free));
    ctrl.largest_first = largest_first;

    feed_item       = '0;
    feed_item.valid = rd_valid;
    feed_item.value = rd_value;
    feed_item.count = rd_count;
    feed_item.idx   = rd_idx;

    wrap_item = held[0];
    if (state == S_SUB) begin
      wrap_item.take = take;
    end else if (state == S_WALK) begin
      wrap_item.take = '0;
    end
  end

  // table write on load, sequential read while feeding the chain
  always_ff @(posedge clk) begin
    if (in_acc && (command == gbcd_pkg::CMD_LOAD) && load_ok) begin
      tbl_value[used[AW-1:0]] <= denom_value;
      tbl_count[used[AW-1:0]] <= denom_count;
    end
    rd_value <= tbl_value[feed_cnt[AW-1:0]];
    rd_count <= tbl_count[feed_cnt[AW-1:0]];
    rd_idx   <= gbcd_pkg::IDX_W'(feed_cnt);
  end

  // cell chain
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    gbcd_pkg::gbcd_item_t left_in;
    gbcd_pkg::gbcd_item_t right_in;
    if (g == 0) begin : g_head
      assign left_in = feed_item;
    end else begin : g_body
      assign left_in = pass[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right_in = wrap_item;
    end else begin : g_inner
      assign right_in = held[g+1];
    end
    gbcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .left_in  (left_in),
      .right_in (right_in),
      .held     (held[g]),
      .pass     (pass[g])
    );
  end

  gbcd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem),
    .divisor  (held[0].value),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      largest_first <= 1'b1;
      used          <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        largest_first <= cfg_wr_data;
      end
      rd_valid <= (state == S_FEED) && (feed_cnt < FW'(used));
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (command)
              gbcd_pkg::CMD_LOAD: begin
                out_valid <= 1'b1;
                out_value <= '0;
                out_count <= '0;
                last      <= 1'b1;
                if (load_ok) begin
                  status <= gbcd_pkg::ST_LOADED;
                  used   <= used + UW'(1);
                end else begin
                  status <= gbcd_pkg::ST_REJECTED;
                end
              end
              gbcd_pkg::CMD_DISPENSE: begin
                rem      <= amount;
                feed_cnt <= '0;
                lines    <= '0;
                state    <= S_FEED;
              end
              gbcd_pkg::CMD_CLEAR: begin
                used      <= '0;
                out_valid <= 1'b1;
                status    <= gbcd_pkg::ST_CLEARED;
                out_value <= '0;
                out_count <= '0;
                last      <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_FEED: begin
          feed_cnt <= feed_cnt + FW'(1);
          if (feed_cnt == FW'(used) + FW'(TABLE_DEPTH)) begin
            step  <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (head_live) begin
            state <= S_DIV;
          end else if (step_end) begin
            state <= S_CHECK;
          end else begin
            step <= step + UW'(1);
          end
        end
        S_DIV: begin
          if (div_done) begin
            take  <= take_next;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= take * held[0].value;
          state <= S_SUB;
        end
        S_SUB: begin
          rem <= rem - prod[gbcd_pkg::AMT_W-1:0];
          if (take != '0) begin
            lines <= lines + UW'(1);
          end
          if (step_end) begin
            state <= S_CHECK;
          end else begin
            step  <= step + UW'(1);
            state <= S_WALK;
          end
        end
        S_CHECK: begin
          if (!fail && (lines != '0)) begin
            step    <= '0;
            emitted <= '0;
            state   <= S_EMIT;
          end else if (out_free) begin
            out_valid <= 1'b1;
            status    <= fail ? gbcd_pkg::ST_IMPOSSIBLE : gbcd_pkg::ST_NOTHING;
            out_value <= '0;
            out_count <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (is_line && out_free) begin
            out_valid <= 1'b1;
            status    <= gbcd_pkg::ST_LINE;
            out_value <= held[0].value;
            out_count <= held[0].take;
            last      <= ((emitted + UW'(1)) == lines);
            emitted   <= emitted + UW'(1);
          end
          if (!is_line || out_free) begin
            if (step_end) begin
              state <= S_IDLE;
            end else begin
              step <= step + UW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/gbcd_check.sv
// ----------------------------------------------------------------------------
// gbcd_check
// Port-level checks of the dispenser, bound to the top level.
// ----------------------------------------------------------------------------
module gbcd_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_wr_en,
  input logic                        cfg_wr_data,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  command,
  input logic [gbcd_pkg::VAL_W-1:0]  denom_value,
  input logic [gbcd_pkg::CNT_W-1:0]  denom_count,
  input logic [gbcd_pkg::AMT_W-1:0]  amount,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [2:0]                  status,
  input logic [gbcd_pkg::VAL_W-1:0]  out_value,
  input logic [gbcd_pkg::CNT_W-1:0]  out_count,
  input logic                        last
);

  // reset drops any pending result
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(out_value) &&
                                  $stable(out_count) && $stable(last)))
    else $error("stalled result changed");

  // a load is answered on the next edge with a single closing beat
  a_load_reply: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (command == gbcd_pkg::CMD_LOAD)) |=>
      (out_valid && last && ((status == gbcd_pkg::ST_LOADED) ||
                             (status == gbcd_pkg::ST_REJECTED))))
    else $error("load not answered");

  // dispense lines carry a denomination and a nonzero take
  a_line_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == gbcd_pkg::ST_LINE)) |-> ((out_value != '0) && (out_count != '0)))
    else $error("empty dispense line");

  // every non-line result stands alone with zero payload
  a_single_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != gbcd_pkg::ST_LINE)) |->
      (last && (out_value == '0) && (out_count == '0)))
    else $error("malformed single result");

endmodule

bind greedy_bounded_change_dispenser gbcd_check u_gbcd_check (.*);

FILE: tb/sv/tb_greedy_bounded_change_dispenser.sv
// ----------------------------------------------------------------------------
// tb_greedy_bounded_change_dispenser
// Self-checking bench for the change dispenser. Loads, clears and dispenses
// are driven over the valid/stall input channel, and a scoreboard keeps its
// own copy of the table and visit order. It predicts every result beat and
// checks them in order. Runs a directed opening, then four random phases
// that cover both visit orders, sender and receiver idling, a long output
// hold and a full drain.
// ----------------------------------------------------------------------------
module tb_greedy_bounded_change_dispenser;

  localparam int unsigned VAL_W         = gbcd_pkg::VAL_W;
  localparam int unsigned CNT_W         = gbcd_pkg::CNT_W;
  localparam int unsigned AMT_W         = gbcd_pkg::AMT_W;
  localparam int unsigned TB_DEPTH      = 16;
  localparam int unsigned QUIET_CYCLES  = 600;   // longer than a full dispense
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint unsigned WATCHDOG_TIME = 64'd20_000_000;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;

  // Expected result beat
  typedef struct packed {
    gbcd_pkg::status_t status;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
    logic              last;
  } change_result_t;

  // Table copy, visit order and queue of results still due
  class change_scoreboard;
    change_result_t   due_results[$];
    logic             largest_first = 1'b1;
    logic [VAL_W-1:0] denom_vals[TB_DEPTH];
    logic [CNT_W-1:0] denom_cnts[TB_DEPTH];
    int unsigned      entries_used = 0;
    int unsigned      mismatches = 0;
    int unsigned      results_seen = 0;
    int unsigned      status_seen[8];

    function void set_order(logic lf);
      largest_first = lf;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void push_single(gbcd_pkg::status_t st);
      change_result_t r;
      r = '{status: st, value: '0, count: '0, last: 1'b1};
      due_results = {due_results, r};
    endfunction

    // Work out the results caused by one accepted input beat
    function void note_beat(logic [1:0] cmd, logic [VAL_W-1:0] val_in,
                            logic [CNT_W-1:0] cnt_in, logic [AMT_W-1:0] amt);
      int unsigned     order[TB_DEPTH];
      change_result_t  lines_q[$];
      change_result_t  line_r;
      longint unsigned remaining, take, val;
      int unsigned     i, j;
      case (cmd)
        gbcd_pkg::CMD_LOAD: begin
          if (val_in == 0 || entries_used >= TB_DEPTH) begin
            push_single(gbcd_pkg::ST_REJECTED);
          end else begin
            denom_vals[entries_used] = val_in;
            denom_cnts[entries_used] = cnt_in;
            entries_used++;
            push_single(gbcd_pkg::ST_LOADED);
          end
        end
        gbcd_pkg::CMD_CLEAR: begin
          entries_used = 0;
          push_single(gbcd_pkg::ST_CLEARED);
        end
        gbcd_pkg::CMD_DISPENSE: begin
          // stable insertion sort: equal values keep load order
          for (i = 0; i < entries_used; i++) begin
            j = i;
            while (j > 0 && (largest_first ? (denom_vals[order[j-1]] < denom_vals[i])
                                           : (denom_vals[order[j-1]] > denom_vals[i]))) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = i;
          end
          // greedy walk
          remaining = amt;
          for (i = 0; i < entries_used; i++) begin
            val  = denom_vals[order[i]];
            take = denom_cnts[order[i]];
            if (val == 0) continue;
            if (remaining / val < take) take = remaining / val;
            if (take > 0) begin
              line_r = '{status: gbcd_pkg::ST_LINE, value: val[VAL_W-1:0],
                         count: take[CNT_W-1:0], last: 1'b0};
              lines_q = {lines_q, line_r};
              remaining -= take * val;
            end
          end
          if (remaining != 0 || lines_q.size() > gbcd_pkg::MAX_RESULTS) begin
            push_single(gbcd_pkg::ST_IMPOSSIBLE);
          end else if (lines_q.size() == 0) begin
            push_single(gbcd_pkg::ST_NOTHING);
          end else begin
            lines_q[lines_q.size()-1].last = 1'b1;
            due_results = {due_results, lines_q};
          end
        end
        default: ;  // unused code: no result, state kept
      endcase
    endfunction

    // Compare one accepted result beat with the oldest expectation
    function void check_result(logic [2:0] st, logic [VAL_W-1:0] val,
                               logic [CNT_W-1:0] cnt, logic lst);
      change_result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status=%0d value=%0d count=%0d last=%0d",
                   st, val, cnt, lst);
        return;
      end
      want = due_results.pop_front();
      if (st !== want.status || val !== want.value || cnt !== want.count ||
          lst !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch: expected status=%0d value=%0d count=%0d last=%0d,",
                    " got status=%0d value=%0d count=%0d last=%0d"},
                   want.status, want.value, want.count, want.last, st, val, cnt, lst);
      end else begin
        status_seen[want.status]++;
      end
    endfunction
  endclass

  // Clock, reset and block inputs, all known from time zero
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_wr_data = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       command = gbcd_pkg::CMD_LOAD;
  logic [VAL_W-1:0] denom_value = '0;
  logic [CNT_W-1:0] denom_count = '0;
  logic [AMT_W-1:0] amount = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       status;
  logic [VAL_W-1:0] out_value;
  logic [CNT_W-1:0] out_count;
  logic             last;

  change_scoreboard change_sb = new;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      items_sent = 0;
  bit               long_hold_req = 1'b0;
  int unsigned      hold_left = 0;

  always #4 clk = ~clk;

  greedy_bounded_change_dispenser #(
    .TABLE_DEPTH (TB_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .denom_value (denom_value),
    .denom_count (denom_count),
    .amount      (amount),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_value   (out_value),
    .out_count   (out_count),
    .last        (last)
  );

  // Output side: check accepted beats, stall at random or for a long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        change_sb.check_result(status, out_value, out_count, last);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one input beat, with random idle cycles ahead of it
  task automatic send_beat(logic [1:0] cmd, logic [VAL_W-1:0] val,
                           logic [CNT_W-1:0] cnt, logic [AMT_W-1:0] amt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    denom_value <= val;
    denom_count <= cnt;
    amount      <= amt;
    do @(posedge clk); while (in_stall);
    change_sb.note_beat(cmd, val, cnt, amt);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Sender pauses until every due result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (change_sb.pending() != 0) @(posedge clk);
  endtask

  // Visit order may only change while the block is idle
  task automatic write_order(logic lf);
    wait_results_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lf;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    change_sb.set_order(lf);
  endtask

  // Mostly small values so dispenses land exactly; some wide ones for bit coverage
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return VAL_W'($urandom_range(1, 20));
      5, 6:          return VAL_W'($urandom_range(1, 1000));
      7:             return VAL_W'(1 << $urandom_range(0, VAL_W - 1));
      default:       return VAL_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CNT_W'($urandom_range(0, 10));
      5, 6, 7:       return CNT_W'($urandom_range(0, 1000));
      default:       return CNT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Usually clear, load a table, then dispense amounts mostly built from that table
  task automatic run_sequence();
    logic [VAL_W-1:0] vals[TB_DEPTH];
    logic [CNT_W-1:0] cnts[TB_DEPTH];
    logic [AMT_W-1:0] amt;
    longint unsigned  sum, part;
    int unsigned      n_load, i;
    if ($urandom_range(0, 99) < 85)
      send_beat(gbcd_pkg::CMD_CLEAR, VAL_W'($urandom), CNT_W'($urandom), AMT_W'($urandom));
    n_load = $urandom_range(1, TB_DEPTH);
    for (i = 0; i < n_load; i++) begin
      vals[i] = pick_value();
      cnts[i] = pick_count();
      send_beat(gbcd_pkg::CMD_LOAD, vals[i], cnts[i], AMT_W'($urandom));
    end
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1: amt = AMT_W'($urandom);
        2:    amt = AMT_W'($urandom_range(0, 1000));
        default: begin
          sum = 0;
          for (i = 0; i < n_load; i++) begin
            if ($urandom_range(0, 1)) begin
              part = longint'(vals[i]) * $urandom_range(0, cnts[i]);
              if (sum + part <= 64'hFF_FFFF) sum += part;
            end
          end
          amt = sum[AMT_W-1:0];
        end
      endcase
      send_beat(gbcd_pkg::CMD_DISPENSE, VAL_W'($urandom), CNT_W'($urandom), amt);
    end
  endtask

  // Random mix: mostly well-formed sequences, some stray beats
  task automatic run_random(int unsigned n_items);
    int unsigned target;
    logic [VAL_W-1:0] val;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        run_sequence();
      end else begin
        val = ($urandom_range(0, 4) == 0) ? '0 : pick_value();
        send_beat(2'($urandom_range(0, 3)), val, pick_count(),
                  ($urandom_range(0, 1) ? AMT_W'($urandom) : AMT_W'($urandom_range(0, 50))));
      end
    end
  endtask

  // Watchdog
  initial begin
    #(WATCHDOG_TIME);
    $display("tb_greedy_bounded_change_dispenser: FAIL");
    $finish;
  end

  initial begin
    int unsigned i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening, reset visit order (largest first)
    send_beat(gbcd_pkg::CMD_DISPENSE, '0, '0, '0);           // empty table, zero amount
    send_beat(gbcd_pkg::CMD_DISPENSE, '0, '0, 24'd5);        // empty table, unmet amount
    send_beat(gbcd_pkg::CMD_LOAD, '0, 16'd5, '0);            // zero value rejected
    send_beat(gbcd_pkg::CMD_LOAD, 16'hFFFF, 16'hFFFF, '0);
    send_beat(gbcd_pkg::CMD_LOAD, 16'd1, 16'd0, '0);         // zero units
    send_beat(gbcd_pkg::CMD_LOAD, 16'd5, 16'd3, '0);
    send_beat(gbcd_pkg::CMD_LOAD, 16'd5, 16'd2, '0);         // equal value, later load
    send_beat(gbcd_pkg::CMD_LOAD, 16'd2, 16'hFFFF, '0);
    send_beat(gbcd_pkg::CMD_LOAD, 16'd1, 16'd4, '0);
    send_beat(gbcd_pkg::CMD_DISPENSE, '0, '0, 24'hFF_FFFF);  // largest amount
    send_beat(gbcd_pkg::CMD_DISPENSE, '0, '0, 24'd1);
    send_beat(gbcd_pkg::CMD_DISPENSE, '0, '0, 24'd3);
    send_beat(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
    for (i = 0; i < 10; i++)
      send_beat(gbcd_pkg::CMD_LOAD, (16'h0040 << i) | 16'(i), 16'hFFFF >> i, '0);
    send_beat(gbcd_pkg::CMD_LOAD, 16'd7, 16'd7, '0);         // table full, rejected
    send_beat(gbcd_pkg::CMD_DISPENSE, '0, '0, 24'h80_0001);
    send_beat(gbcd_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);

    // Sender idles lightly, receiver heavily
    write_order(1'b1);
    send_idle_pct = 10;
    recv_idle_pct = 82;
    run_random(125);

    // Swapped idling, smallest first
    write_order(1'b0);
    send_idle_pct = 82;
    recv_idle_pct = 10;
    run_random(125);

    // No idling; long output hold, then a full drain mid-phase
    write_order(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    run_random(60);
    wait_results_drained();
    run_random(65);

    write_order(1'b0);
    run_random(125);

    // Let the last results come home
    wait_results_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (change_sb.pending() != 0) begin
      $display("%0d expected results never arrived", change_sb.pending());
      change_sb.mismatches += change_sb.pending();
    end

    $display("Covered %0d input beats, %0d result beats: %0d lines, %0d impossible, %0d empty,",
             items_sent, change_sb.results_seen, change_sb.status_seen[gbcd_pkg::ST_LINE],
             change_sb.status_seen[gbcd_pkg::ST_IMPOSSIBLE],
             change_sb.status_seen[gbcd_pkg::ST_NOTHING]);
    $display("%0d loads, %0d rejected loads, %0d clears, both visit orders, long hold, drain.",
             change_sb.status_seen[gbcd_pkg::ST_LOADED],
             change_sb.status_seen[gbcd_pkg::ST_REJECTED],
             change_sb.status_seen[gbcd_pkg::ST_CLEARED]);
    if (change_sb.mismatches == 0) begin
      $display("tb_greedy_bounded_change_dispenser: PASS");
    end else begin
      $display("tb_greedy_bounded_change_dispenser: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gbcd_pkg.sv
rtl/gbcd_cell.sv
rtl/gbcd_div.sv
rtl/greedy_bounded_change_dispenser.sv
rtl/gbcd_check.sv
tb/sv/tb_greedy_bounded_change_dispenser.sv
